// ----- rtl/cdn_pkg.sv -----
// constants and a month table helper shared by the day number converter
`default_nettype none
package cdn_pkg;

    localparam logic [31:0] DN_MIN        = 32'd1721057;
    localparam logic [31:0] DN_MAX        = 32'd25657590;
    localparam logic [31:0] DN_GREG_START = 32'd2299160;
    localparam logic [31:0] GREG_EPOCH    = 32'd1721119;
    localparam logic [31:0] JUL_EPOCH     = 32'd1719656;
    localparam logic [16:0] SECS_DAY      = 17'd86400;
    localparam logic [16:0] SECS_HOUR     = 17'd3600;
    localparam logic [16:0] SECS_MIN      = 17'd60;
    localparam logic [31:0] GREG_BIAS     = 32'd32046;
    localparam logic [31:0] JUL_BIAS      = 32'd32084;
    localparam logic [16:0] YEAR_SHIFT    = 17'd4800;
    localparam logic [15:0] REFORM_YEAR   = 16'd1582;
    localparam logic [7:0]  REFORM_MONTH  = 8'd10;
    localparam logic [7:0]  REFORM_DAY    = 8'd15;
    localparam int          ERA_DAYS      = 146097;
    localparam int          QUAD_DAYS     = 1461;
    localparam int          CENT_DAYS     = 36524;
    localparam int          YEAR_DAYS     = 365;
    localparam logic [27:0] RECIP_25      = 28'd5243;
    localparam logic [25:0] RECIP_225     = 26'd4661;
    localparam logic [20:0] RECIP_15      = 21'd1093;

    // day offset of each month in a year that starts on 1 March
    function automatic logic [8:0] month_start(input logic [3:0] idx);
        logic [8:0] v;
        unique case (idx)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/calendar_day_number_converter.sv -----
// top level of the calendar date / day number converter
// Input channel: i_valid, o_stall and the payload i_op, i_time_word, i_date_word.
// A beat is taken at a rising edge where i_valid is high and o_stall is low.
// Output channel: o_valid, i_stall and o_time_result, o_date_result, o_error.
// i_op 0 turns a packed time and date into seconds and a midnight based day number,
// i_op 1 turns seconds and a day number back into packed time and date.
// Bad operands give o_error high with both results zero.
// Throughput: one beat per cycle while o_stall is low; the two constant
// dividers (by 146097 and by 1461) are three stage pipelines and every other
// step is one register stage.
// Reset (synchronous, active low) empties the pipeline and the output stage.
// When the receiver stalls, the held result stays and one more finished beat
// is caught in a skid register; o_stall then rises and the whole pipeline
// holds until the receiver takes the held beat.
`default_nettype none
module calendar_day_number_converter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_op,
    input  wire logic [31:0] i_time_word,
    input  wire logic [31:0] i_date_word,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [20:0]      o_time_result,
    output logic [31:0]      o_date_result,
    output logic             o_error
);
    import cdn_pkg::*;

    typedef struct packed {
        logic        op;
        logic        err;
        logic        greg;
        logic [23:0] tw;
        logic [31:0] dw;
        logic [19:0] zj;
    } t_side_a;

    typedef struct packed {
        logic        op;
        logic        err;
        logic        greg;
        logic [7:0]  era;
        logic [1:0]  cent;
        logic [4:0]  hour;
        logic [16:0] tw;
        logic [16:0] tres0;
        logic [4:0]  day;
        logic [3:0]  tidx;
        logic [16:0] y;
        logic [9:0]  q100;
        logic [7:0]  q400;
        logic [25:0] y365;
        logic        fgreg;
    } t_side_b;

    localparam int AQW = 8;
    localparam int BQW = 10;

    logic en;

    // decode at the input
    logic       in_err;
    logic [7:0] in_h, in_m, in_s, in_mon, in_day;

    always_comb begin
        in_h   = i_time_word[23:16];
        in_m   = i_time_word[15:8];
        in_s   = i_time_word[7:0];
        in_mon = i_date_word[15:8];
        in_day = i_date_word[7:0];
        if (!i_op) begin
            in_err = (in_h > 8'd23) || (in_m > 8'd59) || (in_s > 8'd59) ||
                     (in_mon < 8'd1) || (in_mon > 8'd12) ||
                     (in_day < 8'd1) || (in_day > 8'd31);
        end else begin
            in_err = (i_time_word >= 32'(SECS_DAY)) || (i_date_word < DN_MIN) ||
                     (i_date_word > DN_MAX);
        end
    end

    logic        r_s0_v;
    t_side_a     r_s0_side;
    logic [24:0] r_s0_zg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (en) begin
            r_s0_v         <= i_valid;
            r_s0_side.op   <= i_op;
            r_s0_side.err  <= in_err;
            r_s0_side.greg <= (i_date_word >= DN_GREG_START);
            r_s0_side.tw   <= i_time_word[23:0];
            r_s0_side.dw   <= i_date_word;
            r_s0_side.zj   <= 20'(i_date_word - JUL_EPOCH);
            r_s0_zg        <= 25'(i_date_word - GREG_EPOCH);
        end
    end

    // 400 year eras
    logic              a_v;
    logic [AQW-1:0]    a_q;
    logic [17:0]       a_r;
    logic [$bits(t_side_a)-1:0] a_side_w;
    t_side_a           a_side;

    cdn_cdiv #(
        .XW (25),
        .QW (AQW),
        .D  (ERA_DAYS),
        .SW ($bits(t_side_a))
    ) u_div_era (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s0_v),
        .i_x     (r_s0_zg),
        .i_side  (r_s0_side),
        .o_valid (a_v),
        .o_q     (a_q),
        .o_r     (a_r),
        .o_side  (a_side_w)
    );

    assign a_side = t_side_a'(a_side_w);

    // centuries, and forward conversion products
    logic [1:0]  s4_c;
    logic [17:0] s4_doc;
    logic [7:0]  s4_mon;
    logic        s4_a;
    logic [16:0] s4_y;
    logic [7:0]  s4_tidx;
    logic [27:0] s4_p100, s4_p400;
    logic [25:0] s4_ph;
    logic [15:0] s4_year;
    logic        s4_fgreg;

    always_comb begin
        s4_c = 2'(a_r >= 18'(CENT_DAYS)) + 2'(a_r >= 18'(2*CENT_DAYS)) +
               2'(a_r >= 18'(3*CENT_DAYS));
        s4_doc  = a_r - 18'(18'(s4_c) * 18'(CENT_DAYS));
        s4_year = a_side.dw[31:16];
        s4_mon  = a_side.dw[15:8];
        s4_a    = (s4_mon <= 8'd2);
        s4_y    = 17'(s4_year) + YEAR_SHIFT - 17'(s4_a);
        s4_tidx = s4_mon + (s4_a ? 8'd12 : 8'd0) - 8'd3;
        s4_p100 = 28'(s4_y[16:2]) * RECIP_25;
        s4_p400 = 28'(s4_y[16:4]) * RECIP_25;
        s4_ph   = 26'(a_side.tw[16:4]) * RECIP_225;
        if (s4_year != REFORM_YEAR) begin
            s4_fgreg = (s4_year > REFORM_YEAR);
        end else if (s4_mon != REFORM_MONTH) begin
            s4_fgreg = (s4_mon > REFORM_MONTH);
        end else begin
            s4_fgreg = (a_side.dw[7:0] >= REFORM_DAY);
        end
    end

    logic        r_s4_v;
    logic [19:0] r_s4_x;
    t_side_b     r_s4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else if (en) begin
            r_s4_v          <= a_v;
            r_s4_x          <= a_side.greg ? 20'(s4_doc) : a_side.zj;
            r_s4_side.op    <= a_side.op;
            r_s4_side.err   <= a_side.err;
            r_s4_side.greg  <= a_side.greg;
            r_s4_side.era   <= a_side.greg ? a_q : 8'd0;
            r_s4_side.cent  <= a_side.greg ? s4_c : 2'd0;
            r_s4_side.hour  <= s4_ph[24:20];
            r_s4_side.tw    <= a_side.tw[16:0];
            r_s4_side.tres0 <= 17'(a_side.tw[23:16]) * SECS_HOUR +
                               17'(a_side.tw[15:8]) * SECS_MIN + 17'(a_side.tw[7:0]);
            r_s4_side.day   <= a_side.dw[4:0];
            r_s4_side.tidx  <= s4_tidx[3:0];
            r_s4_side.y     <= s4_y;
            r_s4_side.q100  <= s4_p100[26:17];
            r_s4_side.q400  <= s4_p400[24:17];
            r_s4_side.y365  <= 26'(s4_y) * 26'(YEAR_DAYS);
            r_s4_side.fgreg <= s4_fgreg;
        end
    end

    // four year groups
    logic              b_v;
    logic [BQW-1:0]    b_q;
    logic [10:0]       b_r;
    logic [$bits(t_side_b)-1:0] b_side_w;
    t_side_b           b_side;

    cdn_cdiv #(
        .XW (20),
        .QW (BQW),
        .D  (QUAD_DAYS),
        .SW ($bits(t_side_b))
    ) u_div_quad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s4_v),
        .i_x     (r_s4_x),
        .i_side  (r_s4_side),
        .o_valid (b_v),
        .o_q     (b_q),
        .o_r     (b_r),
        .o_side  (b_side_w)
    );

    assign b_side = t_side_b'(b_side_w);

    // year in group, day of year, forward day number
    logic [1:0]  s8_yy;
    logic [31:0] s8_sub;

    always_comb begin
        s8_yy = 2'(b_r >= 11'(YEAR_DAYS)) + 2'(b_r >= 11'(2*YEAR_DAYS)) +
                2'(b_r >= 11'(3*YEAR_DAYS));
        s8_sub = b_side.fgreg ? (32'(b_side.q100) - 32'(b_side.q400) + GREG_BIAS)
                              : JUL_BIAS;
    end

    logic        r_s8_v, r_s8_op, r_s8_err, r_s8_greg;
    logic [16:0] r_s8_yb;
    logic [8:0]  r_s8_doy;
    logic [11:0] r_s8_rem;
    logic [4:0]  r_s8_hour;
    logic [16:0] r_s8_tres0;
    logic [31:0] r_s8_fdres;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_v <= 1'b0;
        end else if (en) begin
            r_s8_v     <= b_v;
            r_s8_op    <= b_side.op;
            r_s8_err   <= b_side.err;
            r_s8_greg  <= b_side.greg;
            r_s8_yb    <= 17'(b_side.era) * 17'd400 + 17'(b_side.cent) * 17'd100 +
                          17'(b_q) * 17'd4 + 17'(s8_yy);
            r_s8_doy   <= 9'(b_r - 11'(11'(s8_yy) * 11'(YEAR_DAYS)));
            r_s8_rem   <= 12'(b_side.tw - 17'(b_side.hour) * SECS_HOUR);
            r_s8_hour  <= b_side.hour;
            r_s8_tres0 <= b_side.tres0;
            r_s8_fdres <= 32'(b_side.day) + 32'(month_start(b_side.tidx)) +
                          32'(b_side.y365) + 32'(b_side.y[16:2]) - s8_sub;
        end
    end

    // month of the shifted year, minutes
    logic [3:0]  s9_mp;
    logic [20:0] s9_pm;

    always_comb begin
        s9_mp = 4'd0;
        for (int k = 1; k < 12; k++) begin
            s9_mp = s9_mp + 4'(r_s8_doy >= month_start(4'(k)));
        end
        s9_pm = 21'(r_s8_rem[11:2]) * RECIP_15;
    end

    logic        r_s9_v, r_s9_op, r_s9_err, r_s9_greg;
    logic [16:0] r_s9_yb;
    logic [8:0]  r_s9_doy;
    logic [3:0]  r_s9_mp;
    logic [11:0] r_s9_rem;
    logic [5:0]  r_s9_min;
    logic [4:0]  r_s9_hour;
    logic [16:0] r_s9_tres0;
    logic [31:0] r_s9_fdres;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s9_v <= 1'b0;
        end else if (en) begin
            r_s9_v     <= r_s8_v;
            r_s9_op    <= r_s8_op;
            r_s9_err   <= r_s8_err;
            r_s9_greg  <= r_s8_greg;
            r_s9_yb    <= r_s8_yb;
            r_s9_doy   <= r_s8_doy;
            r_s9_mp    <= s9_mp;
            r_s9_rem   <= r_s8_rem;
            r_s9_min   <= s9_pm[19:14];
            r_s9_hour  <= r_s8_hour;
            r_s9_tres0 <= r_s8_tres0;
            r_s9_fdres <= r_s8_fdres;
        end
    end

    // final fields and result selection
    logic [4:0]  s10_d;
    logic [3:0]  s10_m;
    logic [16:0] s10_year;
    logic [5:0]  s10_sec;
    logic [20:0] s10_tres;
    logic [31:0] s10_dres;

    always_comb begin
        s10_d    = 5'(r_s9_doy - month_start(r_s9_mp) + 9'd1);
        s10_m    = (r_s9_mp < 4'd10) ? (r_s9_mp + 4'd3) : (r_s9_mp - 4'd9);
        s10_year = r_s9_yb + 17'(s10_m <= 4'd2) - (r_s9_greg ? 17'd0 : 17'd4);
        s10_sec  = 6'(r_s9_rem - 12'(12'(r_s9_min) * 12'd60));
        if (r_s9_err) begin
            s10_tres = 21'd0;
            s10_dres = 32'd0;
        end else if (!r_s9_op) begin
            s10_tres = 21'(r_s9_tres0);
            s10_dres = r_s9_fdres;
        end else begin
            s10_tres = {r_s9_hour, 2'b00, r_s9_min, 2'b00, s10_sec};
            s10_dres = {s10_year[15:0], 4'd0, s10_m, 3'd0, s10_d};
        end
    end

    logic        r_s10_v, r_s10_err;
    logic [20:0] r_s10_tres;
    logic [31:0] r_s10_dres;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s10_v <= 1'b0;
        end else if (en) begin
            r_s10_v    <= r_s9_v;
            r_s10_err  <= r_s9_err;
            r_s10_tres <= s10_tres;
            r_s10_dres <= s10_dres;
        end
    end

    // output register and skid
    logic        r_out_v, r_out_err, r_skid_v, r_skid_err;
    logic [20:0] r_out_tres, r_skid_tres;
    logic [31:0] r_out_dres, r_skid_dres;

    assign en = !r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (!i_stall) begin
                r_out_err  <= r_skid_err;
                r_out_tres <= r_skid_tres;
                r_out_dres <= r_skid_dres;
                r_skid_v   <= 1'b0;
            end
        end else if (!r_out_v || !i_stall) begin
            r_out_v    <= r_s10_v;
            r_out_err  <= r_s10_err;
            r_out_tres <= r_s10_tres;
            r_out_dres <= r_s10_dres;
        end else if (r_s10_v) begin
            r_skid_v    <= 1'b1;
            r_skid_err  <= r_s10_err;
            r_skid_tres <= r_s10_tres;
            r_skid_dres <= r_s10_dres;
        end
    end

    assign o_stall       = r_skid_v;
    assign o_valid       = r_out_v;
    assign o_error       = r_out_err;
    assign o_time_result = r_out_tres;
    assign o_date_result = r_out_dres;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> o_time_result == 21'd0 && o_date_result == 32'd0)
        else $error("error beat carries non-zero results");

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds a beat while the output is empty");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v && !i_stall |=> r_out_v && !r_skid_v)
        else $error("skid beat not moved to the output");

endmodule
`default_nettype wire

// ----- rtl/cdn_cdiv.sv -----
// three stage divider by a constant with a sideband carried alongside
`default_nettype none
module cdn_cdiv #(
    parameter int XW = 20,
    parameter int QW = 10,
    parameter int D  = 1461,
    parameter int SW = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_valid,
    input  wire logic [XW-1:0]          i_x,
    input  wire logic [SW-1:0]          i_side,
    output logic                        o_valid,
    output logic [QW-1:0]               o_q,
    output logic [$clog2(D)-1:0]        o_r,
    output logic [SW-1:0]               o_side
);
    localparam int RW = $clog2(D);
    localparam logic [XW:0] RECIP = (XW+1)'((64'd1 << XW) / D);

    logic [2*XW-1:0] w_prod;
    logic [XW-1:0]   w_qd;
    logic [XW-1:0]   w_rem;

    logic            r_s1_v, r_s2_v, r_s3_v;
    logic [XW-1:0]   r_s1_x;
    logic [QW-1:0]   r_s1_q, r_s2_q, r_s3_q;
    logic [RW:0]     r_s2_r;
    logic [RW-1:0]   r_s3_r;
    logic [SW-1:0]   r_s1_side, r_s2_side, r_s3_side;

    assign w_prod = (2*XW)'(i_x) * (2*XW)'(RECIP);
    assign w_qd   = XW'((2*XW)'(r_s1_q) * (2*XW)'(D));
    assign w_rem  = r_s1_x - w_qd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else if (i_en) begin
            r_s1_v    <= i_valid;
            r_s1_x    <= i_x;
            r_s1_q    <= QW'(w_prod >> XW);
            r_s1_side <= i_side;
            r_s2_v    <= r_s1_v;
            r_s2_q    <= r_s1_q;
            r_s2_r    <= (RW+1)'(w_rem);
            r_s2_side <= r_s1_side;
            r_s3_v    <= r_s2_v;
            r_s3_side <= r_s2_side;
            if (r_s2_r >= (RW+1)'(D)) begin
                r_s3_q <= r_s2_q + QW'(1);
                r_s3_r <= RW'(r_s2_r - (RW+1)'(D));
            end else begin
                r_s3_q <= r_s2_q;
                r_s3_r <= RW'(r_s2_r);
            end
        end
    end

    assign o_valid = r_s3_v;
    assign o_q     = r_s3_q;
    assign o_r     = r_s3_r;
    assign o_side  = r_s3_side;
endmodule
`default_nettype wire
